// ===== design/sfu_pkg.sv =====
// Shared types and constants for the signed field unpacker.
package sfu_pkg;

    localparam int BYTE_W     = 8;
    localparam int VAL_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_COUNT  = 2'd1;

    // Raw register fields as seen on the configuration port
    localparam int VALUE_BITS_FIELD_W = 5;
    localparam int LOG_COUNT_FIELD_W  = 4;

    // Register values after reset
    localparam int VALUE_BITS_RST = 13;
    localparam int LOG_COUNT_RST  = 9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXTRACT,
        ST_SEND
    } state_t;

endpackage

// ===== design/signed_field_unpacker_checked_top.sv =====
// Signed fixed-width field unpacker with per-value and per-frame checks.
//
//   channel | signals                                    | flow control
//   --------+--------------------------------------------+-------------------
//   input   | in_valid, data_byte                        | in_stall
//   output  | out_valid, value, value_ok, run_last,      | out_stall
//           | frame_last, frame_ok                       |
//   config  | cfg_valid, cfg_index, cfg_data             | cfg_ready
//
// A byte is loaded in the idle state; each value it yields then passes through
// the shared extract shifter (extract state) and waits in the single output
// register (send state) until it is taken. No new byte is accepted until the
// last value of the byte's run has been taken from the output register.
// in_stall and cfg_ready follow the idle state; in idle a pending config write
// stalls the input. Reset clears the frame and loads the default width and
// count. Output stalls hold the result in place.
module signed_field_unpacker_checked_top #(
    parameter int MAX_LOG_COUNT  = 10,
    parameter int MAX_VALUE_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [sfu_pkg::BYTE_W-1:0]     data_byte,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [sfu_pkg::VAL_W-1:0] value,
    output logic                           value_ok,
    output logic                           run_last,
    output logic                           frame_last,
    output logic                           frame_ok,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sfu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfu_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sfu_pkg::*;

    localparam int ACC_W  = MAX_VALUE_BITS + BYTE_W - 1;
    localparam int HELD_W = $clog2(MAX_VALUE_BITS + BYTE_W);
    localparam int BITS_W = $clog2(MAX_VALUE_BITS + 1);
    localparam int LOG_W  = $clog2(MAX_LOG_COUNT + 1);
    localparam int DONE_W = MAX_LOG_COUNT + 1;
    localparam int VB_W   = MAX_VALUE_BITS;
    localparam int BITS_RST = (VALUE_BITS_RST > MAX_VALUE_BITS) ? MAX_VALUE_BITS
                                                                : VALUE_BITS_RST;
    localparam int LOG_RST  = (LOG_COUNT_RST > MAX_LOG_COUNT) ? MAX_LOG_COUNT
                                                              : LOG_COUNT_RST;

    state_t state_reg, state_next;

    logic [BITS_W-1:0] bits_reg, bits_next;
    logic [LOG_W-1:0]  log_reg, log_next;

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [HELD_W-1:0] held_reg, held_next;
    logic [DONE_W-1:0] done_reg, done_next;
    logic              good_reg, good_next;

    logic signed [VAL_W-1:0] value_reg, value_next;
    logic value_ok_reg, value_ok_next;
    logic run_last_reg, run_last_next;
    logic frame_last_reg, frame_last_next;
    logic frame_ok_reg, frame_ok_next;

    logic in_xfer, out_xfer, cfg_xfer;
    logic [VALUE_BITS_FIELD_W-1:0] cfg_bits_raw;
    logic [LOG_COUNT_FIELD_W-1:0]  cfg_log_raw;

    // Byte load
    logic [ACC_W-1:0]  acc_load;
    logic [HELD_W-1:0] held_load;

    // Shared extract unit
    logic [HELD_W-1:0] held_rem;
    logic [ACC_W-1:0]  acc_shift;
    logic [ACC_W-1:0]  acc_rem;
    logic [VB_W-1:0]   field_mask;
    logic [VB_W-1:0]   sign_mask;
    logic [VB_W-1:0]   field_raw;
    logic signed [VB_W-1:0] field_ext;
    logic              field_ok;
    logic [DONE_W-1:0] done_inc;
    logic [DONE_W-1:0] total;
    logic              at_frame_end;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;
    assign cfg_xfer = cfg_valid && cfg_ready;

    assign cfg_bits_raw = cfg_data[VALUE_BITS_FIELD_W-1:0];
    assign cfg_log_raw  = cfg_data[LOG_COUNT_FIELD_W-1:0];

    assign acc_load  = ACC_W'({acc_reg, data_byte});
    assign held_load = held_reg + HELD_W'(BYTE_W);

    assign held_rem   = held_reg - HELD_W'(bits_reg);
    assign acc_shift  = acc_reg >> held_rem;
    assign acc_rem    = acc_reg & ~({ACC_W{1'b1}} << held_rem);
    assign field_mask = ~({VB_W{1'b1}} << bits_reg);
    assign sign_mask  = VB_W'(1) << (bits_reg - BITS_W'(1));
    assign field_raw  = acc_shift[VB_W-1:0] & field_mask;
    assign field_ok   = (field_raw != sign_mask);
    assign field_ext  = ((field_raw & sign_mask) != '0) ? (field_raw | ~field_mask)
                                                        : field_raw;
    assign done_inc     = done_reg + DONE_W'(1);
    assign total        = DONE_W'(1) << log_reg;
    assign at_frame_end = (done_inc == total);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!cfg_xfer && in_xfer && (held_load >= HELD_W'(bits_reg)))
                    state_next = ST_EXTRACT;
            end
            ST_EXTRACT:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_xfer)
                    state_next = run_last_reg ? ST_IDLE : ST_EXTRACT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        in_stall  = 1'b1;
        cfg_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // config write goes first; the byte is stalled while cfg_valid is high
                in_stall  = cfg_valid;
                cfg_ready = 1'b1;
            end
            ST_EXTRACT:
            begin
                in_stall = 1'b1;
            end
            ST_SEND:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Configuration registers, clamped to the supported range on write
    always_comb
    begin
        bits_next = bits_reg;
        log_next  = log_reg;
        if (cfg_xfer)
        begin
            if (cfg_index == CFG_VALUE_BITS)
            begin
                if (cfg_bits_raw == '0)
                    bits_next = BITS_W'(1);
                else if (cfg_bits_raw > MAX_VALUE_BITS)
                    bits_next = BITS_W'(MAX_VALUE_BITS);
                else
                    bits_next = BITS_W'(cfg_bits_raw);
            end
            else if (cfg_index == CFG_LOG_COUNT)
            begin
                if (cfg_log_raw == '0)
                    log_next = LOG_W'(1);
                else if (cfg_log_raw > MAX_LOG_COUNT)
                    log_next = LOG_W'(MAX_LOG_COUNT);
                else
                    log_next = LOG_W'(cfg_log_raw);
            end
        end
    end

    // Frame state and result register
    always_comb
    begin
        acc_next        = acc_reg;
        held_next       = held_reg;
        done_next       = done_reg;
        good_next       = good_reg;
        value_next      = value_reg;
        value_ok_next   = value_ok_reg;
        run_last_next   = run_last_reg;
        frame_last_next = frame_last_reg;
        frame_ok_next   = frame_ok_reg;

        if (cfg_xfer && (cfg_index == CFG_VALUE_BITS || cfg_index == CFG_LOG_COUNT))
        begin
            // a register write abandons the frame in progress
            acc_next  = '0;
            held_next = '0;
            done_next = '0;
            good_next = 1'b1;
        end
        else if (in_xfer)
        begin
            acc_next  = acc_load;
            held_next = held_load;
        end
        else if (state_reg == ST_EXTRACT)
        begin
            value_next      = VAL_W'(field_ext);
            value_ok_next   = field_ok;
            frame_last_next = at_frame_end;
            frame_ok_next   = at_frame_end && good_reg && field_ok && (acc_rem == '0);
            run_last_next   = at_frame_end || (held_rem < HELD_W'(bits_reg));
            if (at_frame_end)
            begin
                acc_next  = '0;
                held_next = '0;
                done_next = '0;
                good_next = 1'b1;
            end
            else
            begin
                acc_next  = acc_rem;
                held_next = held_rem;
                done_next = done_inc;
                good_next = good_reg && field_ok;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bits_reg  <= BITS_W'(BITS_RST);
            log_reg   <= LOG_W'(LOG_RST);
            acc_reg   <= '0;
            held_reg  <= '0;
            done_reg  <= '0;
            good_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            bits_reg  <= bits_next;
            log_reg   <= log_next;
            acc_reg   <= acc_next;
            held_reg  <= held_next;
            done_reg  <= done_next;
            good_reg  <= good_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        value_ok_reg   <= value_ok_next;
        run_last_reg   <= run_last_next;
        frame_last_reg <= frame_last_next;
        frame_ok_reg   <= frame_ok_next;
    end

    assign value      = value_reg;
    assign value_ok   = value_ok_reg;
    assign run_last   = run_last_reg;
    assign frame_last = frame_last_reg;
    assign frame_ok   = frame_ok_reg;

endmodule

// ===== tb/signed_field_unpacker_checked_top_tb.sv =====
// Self-checking testbench for the signed field unpacker: directed, random and flow-control tests.
module signed_field_unpacker_checked_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfu_pkg::*;

    localparam int MAX_LOG_COUNT  = 10;
    localparam int MAX_VALUE_BITS = 16;
    localparam int DRAIN_CYCLES   = 20;

    // Indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic                    value_ok;
        logic                    run_last;
        logic                    frame_last;
        logic                    frame_ok;
    } decoded_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [BYTE_W-1:0]       data_byte = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [VAL_W-1:0] value;
    logic                    value_ok;
    logic                    run_last;
    logic                    frame_last;
    logic                    frame_ok;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    // Predictor state
    logic [4:0]  reg_width;
    logic [3:0]  reg_log;
    logic [22:0] acc_bits;
    int          held_n;
    int          done_n;
    logic        frame_clean;

    decoded_t    decoded_q[$];
    logic [7:0]  frame_bytes[$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          hold_cycles = 0;

    signed_field_unpacker_checked_top #(
        .MAX_LOG_COUNT  (MAX_LOG_COUNT),
        .MAX_VALUE_BITS (MAX_VALUE_BITS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .value_ok   (value_ok),
        .run_last   (run_last),
        .frame_last (frame_last),
        .frame_ok   (frame_ok),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int eff_width(input logic [4:0] raw);
        if (raw == 5'd0)
            return 1;
        if (raw > MAX_VALUE_BITS)
            return MAX_VALUE_BITS;
        return int'(raw);
    endfunction

    function automatic int eff_log(input logic [3:0] raw);
        if (raw == 4'd0)
            return 1;
        if (raw > MAX_LOG_COUNT)
            return MAX_LOG_COUNT;
        return int'(raw);
    endfunction

    function automatic void clear_frame();
        acc_bits    = '0;
        held_n      = 0;
        done_n      = 0;
        frame_clean = 1'b1;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
        if (idx == CFG_VALUE_BITS)
        begin
            reg_width = d[4:0];
            clear_frame();
        end
        else if (idx == CFG_LOG_COUNT)
        begin
            reg_log = d[3:0];
            clear_frame();
        end
    endfunction

    // Appends one byte and queues every value it completes
    function automatic void unpack_byte(input logic [7:0] b);
        decoded_t    res[8];
        int          n;
        int          w;
        int          total;
        logic [31:0] mask_v;
        logic [31:0] sign_v;
        logic [31:0] field;
        w      = eff_width(reg_width);
        total  = 1 << eff_log(reg_log);
        mask_v = (32'd1 << w) - 32'd1;
        sign_v = 32'd1 << (w - 1);
        n      = 0;
        acc_bits = {acc_bits[14:0], b};
        held_n  += 8;
        while (held_n >= w && done_n < total && n < 8)
        begin
            held_n  -= w;
            field    = ({9'd0, acc_bits} >> held_n) & mask_v;
            acc_bits = acc_bits & 23'((32'd1 << held_n) - 32'd1);
            res[n].value_ok = (field != sign_v);
            if (field == sign_v)
                frame_clean = 1'b0;
            if ((field & sign_v) != 32'd0)
                field = field | ~mask_v;
            res[n].value      = field[15:0];
            res[n].run_last   = 1'b0;
            res[n].frame_last = 1'b0;
            res[n].frame_ok   = 1'b0;
            done_n++;
            n++;
            if (done_n >= total)
            begin
                res[n-1].frame_last = 1'b1;
                res[n-1].frame_ok   = frame_clean && (acc_bits == '0);
                clear_frame();
                break;
            end
        end
        for (int k = 0; k < n; k++)
        begin
            res[k].run_last = (k == n - 1);
            decoded_q.push_back(res[k]);
        end
    endfunction

    function automatic void check_result();
        decoded_t want;
        if (decoded_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected output value=%0d ok=%b run=%b last=%b fok=%b",
                         $realtime, value, value_ok, run_last, frame_last, frame_ok);
        end
        else
        begin
            want = decoded_q.pop_front();
            if (value !== want.value || value_ok !== want.value_ok ||
                run_last !== want.run_last || frame_last !== want.frame_last ||
                frame_ok !== want.frame_ok)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: exp value=%0d ok=%b run=%b last=%b fok=%b, got value=%0d ok=%b run=%b last=%b fok=%b",
                             $realtime, want.value, want.value_ok, want.run_last,
                             want.frame_last, want.frame_ok, value, value_ok,
                             run_last, frame_last, frame_ok);
            end
        end
    endfunction

    // Watches all three channels; results are checked before new bytes are predicted
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            reg_width = 5'(VALUE_BITS_RST);
            reg_log   = 4'(LOG_COUNT_RST);
            clear_frame();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                unpack_byte(data_byte);
        end
    end

    // Receiver: random stall bursts, plus a long counted hold on request
    initial
    begin
        int burst;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
                out_stall <= 1'b0;
            end
            else if (recv_idle > 0 && $urandom_range(0, 99) < recv_idle)
            begin
                burst = $urandom_range(1, 18);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("signed_field_unpacker_checked_top_tb: errors");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (send_idle > 0 && $urandom_range(0, 99) < send_idle)
        begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last transfer
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic set_format(input logic [4:0] wraw, input logic [3:0] lraw);
        wait_drain();
        write_reg(CFG_VALUE_BITS, {11'($urandom), wraw});
        write_reg(CFG_LOG_COUNT, {12'($urandom), lraw});
        cfg_valid <= 1'b0;
    endtask

    // Packs count random values into frame_bytes; some forbidden codes, some dirty padding
    function automatic void build_frame(input int w, input int count);
        logic [31:0] pend;
        logic [31:0] field;
        logic [31:0] mask_v;
        int          pn;
        int          pad;
        frame_bytes.delete();
        mask_v = (32'd1 << w) - 32'd1;
        pend   = '0;
        pn     = 0;
        repeat (count)
        begin
            if ($urandom_range(0, 9) == 0)
                field = 32'd1 << (w - 1);
            else
                field = $urandom & mask_v;
            pend = (pend << w) | field;
            pn  += w;
            while (pn >= 8)
            begin
                pn -= 8;
                frame_bytes.push_back(8'(pend >> pn));
                pend = pend & ((32'd1 << pn) - 32'd1);
            end
        end
        if (pn > 0)
        begin
            pad = 8 - pn;
            if ($urandom_range(0, 5) == 0)
                field = 32'($urandom_range(1, (1 << pad) - 1));
            else
                field = '0;
            frame_bytes.push_back(8'((pend << pad) | field));
        end
    endfunction

    task automatic send_frame(input logic [4:0] wraw, input logic [3:0] lraw,
                              input bit partial);
        int n;
        build_frame(eff_width(wraw), 1 << eff_log(lraw));
        n = partial ? (frame_bytes.size() + 1) / 2 : frame_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(frame_bytes[i]);
    endtask

    // Reset width and count; the frame is left open and dropped by the next write
    task automatic test_reset_defaults();
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h7F);
    endtask

    task automatic test_field_extremes();
        set_format(5'd16, 4'd1);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h01);
        // one-bit values: eight results from one byte
        set_format(5'd1, 4'd3);
        send_byte(8'h00);
        send_byte(8'hFF);
        // zero width and zero count clamp to one
        set_format(5'd0, 4'd0);
        send_byte(8'h40);
        send_byte(8'h20);
        send_byte(8'h00);
        // oversized width and count clamp to the maximum
        set_format(5'd31, 4'd15);
        send_byte(8'h12);
        send_byte(8'h34);
        // frame ends mid-byte with dirty padding
        set_format(5'd3, 4'd1);
        send_byte(8'b011_100_01);
    endtask

    task automatic test_spare_registers();
        set_format(5'd9, 4'd2);
        send_byte(8'hAA);
        wait_drain();
        write_reg(CFG_SPARE_A, 16'($urandom));
        write_reg(CFG_SPARE_B, 16'($urandom));
        cfg_valid <= 1'b0;
        send_byte(8'h55);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'hF0);
    endtask

    task automatic test_random_frames();
        logic [4:0] wraw;
        logic [3:0] lraw;
        int         w;
        int         maxlog;
        int         stop_at;
        int         pick;
        stop_at = items_sent + 230;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 2);
            send_idle = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
            pick = $urandom_range(0, 2);
            recv_idle = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
            case ($urandom_range(0, 11))
                0:       wraw = 5'd0;
                1:       wraw = 5'($urandom_range(17, 31));
                default: wraw = 5'($urandom_range(1, 16));
            endcase
            w = eff_width(wraw);
            // keep frames to 32 bytes or less
            maxlog = 1;
            for (int l = 1; l <= MAX_LOG_COUNT; l++)
                if (((1 << l) * w) <= 256)
                    maxlog = l;
            lraw = 4'($urandom_range(0, maxlog));
            set_format(wraw, lraw);
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        repeat ($urandom_range(1, 5))
                            send_byte(8'($urandom));
                    end
                    1:       send_frame(wraw, lraw, 1'b1);
                    default: send_frame(wraw, lraw, 1'b0);
                endcase
            end
        end
    endtask

    // Long output hold fills the block; then the sender waits for a full drain mid-frame
    task automatic test_backpressure();
        int half;
        send_idle = 0;
        recv_idle = 0;
        set_format(5'd1, 4'd10);
        build_frame(1, 1 << MAX_LOG_COUNT);
        half = frame_bytes.size() / 2;
        hold_cycles = 400;
        for (int i = 0; i < half; i++)
            send_byte(frame_bytes[i]);
        wait_drain();
        recv_idle = 10;
        for (int i = half; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i]);
    endtask

    task automatic test_unstalled_tail();
        logic [4:0] wraw;
        int         stop_at;
        send_idle = 0;
        recv_idle = 0;
        wraw = 5'($urandom_range(4, 13));
        set_format(wraw, 4'd2);
        stop_at = items_sent + 40;
        while (items_sent < stop_at)
            send_frame(wraw, 4'd2, 1'b0);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle = 20;
        recv_idle = 20;
        test_reset_defaults();
        test_field_extremes();
        test_spare_registers();
        test_random_frames();
        test_backpressure();
        test_unstalled_tail();
        wait_drain();
        mismatches += decoded_q.size();
        if (mismatches == 0)
            $display("signed_field_unpacker_checked_top_tb: clean");
        else
            $display("signed_field_unpacker_checked_top_tb: errors");
        $finish;
    end

endmodule

// ===== files.f =====
design/sfu_pkg.sv
design/signed_field_unpacker_checked_top.sv
tb/signed_field_unpacker_checked_top_tb.sv
